// File: rtl/spfr_pkg.sv
// ----------------------------------------------------------------------------
// spfr_pkg
// shared constants, codes, command/status types and helpers of the receiver
// ----------------------------------------------------------------------------
package spfr_pkg;

  localparam int unsigned FrameBytesDef = 64;

  // result kinds
  localparam logic [2:0] KIND_ZERO       = 3'd0;
  localparam logic [2:0] KIND_SYNC       = 3'd1;
  localparam logic [2:0] KIND_BAD_SUM    = 3'd2;
  localparam logic [2:0] KIND_ONES       = 3'd3;
  localparam logic [2:0] KIND_ACCEPTED   = 3'd4;
  localparam logic [2:0] KIND_UNDEF      = 3'd5;
  localparam logic [2:0] KIND_FRAME_GOOD = 3'd6;
  localparam logic [2:0] KIND_FRAME_BAD  = 3'd7;

  // configuration register indexes
  localparam logic [1:0] CFG_MAX_INVALID  = 2'd0;
  localparam logic [1:0] CFG_MAX_CHECKSUM = 2'd1;
  localparam logic [1:0] CFG_MAX_FRAME    = 2'd2;

  localparam logic [7:0] LIMIT_RESET = 8'd10;

  typedef struct packed {
    logic capture;
    logic classify;
    logic write;
    logic inc_rec;
    logic fin_start;
    logic walk_rd;
    logic walk_acc;
    logic judge;
    logic put_single;
    logic emit_rd;
    logic emit_put;
  } spfr_cmd_t;

  typedef struct packed {
    logic do_write;
    logic write_last;
    logic frame_done;
    logic too_long;
    logic walk_last;
    logic sum_ok;
    logic len_zero;
    logic emit_last;
    logic out_free;
  } spfr_sts_t;

  function automatic logic [7:0] sat_inc(input logic [7:0] x);
    return (x == 8'hFF) ? x : x + 8'd1;
  endfunction

  // ceil((len+6)/6) = (len+11)/6, by reciprocal 171/1024 (exact up to 266)
  function automatic logic [5:0] packets_for_len(input logic [7:0] len);
    logic [8:0]  n;
    logic [17:0] p;
    n = {1'b0, len} + 9'd11;
    p = {9'd0, n} * 18'd171;
    return p[15:10];
  endfunction

endpackage

// File: rtl/spfr_core_top.sv
// ----------------------------------------------------------------------------
// spi_packet_frame_receiver_core
// classifies 8-byte spi packets, assembles frames and emits good payloads
// ----------------------------------------------------------------------------
// one packet at a time; in_stall_o is high from the transfer until its last result
// is loaded into the output register, the next packet can be taken in the cycle after the load
// single-result packets are classified and loaded into the output register; stored
// packets write six bytes to the frame store; a completing frame walks the store
// (one read port), then emits its payload bytes; reset: async, control and
// counters clear, the frame store is not cleared (undefined until written)
module spi_packet_frame_receiver_core #(
  parameter int unsigned FRAME_BYTES = spfr_pkg::FrameBytesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration write port
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  // packet input transfer
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] byte_0_i,
  input  logic [7:0] byte_1_i,
  input  logic [7:0] byte_2_i,
  input  logic [7:0] byte_3_i,
  input  logic [7:0] byte_4_i,
  input  logic [7:0] byte_5_i,
  input  logic [7:0] byte_6_i,
  input  logic [7:0] byte_7_i,
  // result output transfer
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] packet_kind_o,
  output logic [7:0] payload_byte_o,
  output logic       last_result_o,
  output logic       reset_request_o,
  output logic       partner_ready_o,
  output logic       ack_needed_o,
  output logic [7:0] ack_id_o,
  output logic [7:0] frame_len_o
);

  spfr_pkg::spfr_cmd_t cmd;
  spfr_pkg::spfr_sts_t sts;

  // sequencer
  spfr_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // checks, counters, frame store and output register
  spfr_dp #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .byte_0_i       (byte_0_i),
    .byte_1_i       (byte_1_i),
    .byte_2_i       (byte_2_i),
    .byte_3_i       (byte_3_i),
    .byte_4_i       (byte_4_i),
    .byte_5_i       (byte_5_i),
    .byte_6_i       (byte_6_i),
    .byte_7_i       (byte_7_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .packet_kind_o  (packet_kind_o),
    .payload_byte_o (payload_byte_o),
    .last_result_o  (last_result_o),
    .reset_request_o(reset_request_o),
    .partner_ready_o(partner_ready_o),
    .ack_needed_o   (ack_needed_o),
    .ack_id_o       (ack_id_o),
    .frame_len_o    (frame_len_o)
  );

endmodule

// File: rtl/spfr_ram.sv
// ----------------------------------------------------------------------------
// spfr_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module spfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/spfr_ctrl.sv
// ----------------------------------------------------------------------------
// spfr_ctrl
// packet sequencer: classify, store, frame check walk and result emission
// ----------------------------------------------------------------------------
module spfr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  spfr_pkg::spfr_sts_t sts_i,
  output spfr_pkg::spfr_cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CLS  = 4'd1;
  localparam logic [3:0] S_WR   = 4'd2;
  localparam logic [3:0] S_INC  = 4'd3;
  localparam logic [3:0] S_DEC  = 4'd4;
  localparam logic [3:0] S_FIN  = 4'd5;
  localparam logic [3:0] S_WRD  = 4'd6;
  localparam logic [3:0] S_WAC  = 4'd7;
  localparam logic [3:0] S_JDG  = 4'd8;
  localparam logic [3:0] S_PUT  = 4'd9;
  localparam logic [3:0] S_ERD  = 4'd10;
  localparam logic [3:0] S_ELD  = 4'd11;

  logic [3:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_CLS;
        end
      end
      S_CLS: begin
        cmd_o.classify = 1'b1;
        state_d        = sts_i.do_write ? S_WR : S_PUT;
      end
      S_WR: begin
        cmd_o.write = 1'b1;
        if (sts_i.write_last) state_d = S_INC;
      end
      S_INC: begin
        cmd_o.inc_rec = 1'b1;
        state_d       = S_DEC;
      end
      S_DEC: begin
        state_d = sts_i.frame_done ? S_FIN : S_PUT;
      end
      S_FIN: begin
        cmd_o.fin_start = 1'b1;
        state_d         = sts_i.too_long ? S_PUT : S_WRD;
      end
      S_WRD: begin
        cmd_o.walk_rd = 1'b1;
        state_d       = S_WAC;
      end
      S_WAC: begin
        cmd_o.walk_acc = 1'b1;
        state_d        = sts_i.walk_last ? S_JDG : S_WRD;
      end
      S_JDG: begin
        cmd_o.judge = 1'b1;
        state_d     = (sts_i.sum_ok && !sts_i.len_zero) ? S_ERD : S_PUT;
      end
      S_PUT: begin
        if (sts_i.out_free) begin
          cmd_o.put_single = 1'b1;
          state_d          = S_IDLE;
        end
      end
      S_ERD: begin
        cmd_o.emit_rd = 1'b1;
        state_d       = S_ELD;
      end
      S_ELD: begin
        if (sts_i.out_free) begin
          cmd_o.emit_put = 1'b1;
          state_d        = sts_i.emit_last ? S_IDLE : S_ERD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/spfr_dp.sv
// ----------------------------------------------------------------------------
// spfr_dp
// receiver datapath: packet checks, counters, frame store and output register
// ----------------------------------------------------------------------------
module spfr_dp #(
  parameter int unsigned FRAME_BYTES = spfr_pkg::FrameBytesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [7:0]          cfg_data_i,
  input  logic [7:0]          byte_0_i,
  input  logic [7:0]          byte_1_i,
  input  logic [7:0]          byte_2_i,
  input  logic [7:0]          byte_3_i,
  input  logic [7:0]          byte_4_i,
  input  logic [7:0]          byte_5_i,
  input  logic [7:0]          byte_6_i,
  input  logic [7:0]          byte_7_i,
  input  spfr_pkg::spfr_cmd_t cmd_i,
  output spfr_pkg::spfr_sts_t sts_o,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic [2:0]          packet_kind_o,
  output logic [7:0]          payload_byte_o,
  output logic                last_result_o,
  output logic                reset_request_o,
  output logic                partner_ready_o,
  output logic                ack_needed_o,
  output logic [7:0]          ack_id_o,
  output logic [7:0]          frame_len_o
);

  localparam int unsigned AW = $clog2(FRAME_BYTES);
  localparam logic [9:0]  FB = 10'(FRAME_BYTES);
  localparam logic [63:0] SyncRev = 64'h1122_3344_5566_7788;

  logic [7:0] max_inv_q, max_cks_q, max_fe_q;
  logic [7:0] b_q [8];
  logic       ready_q;
  logic [7:0] cur_id_q;
  logic [5:0] exp_q, rec_q;
  logic [7:0] inv_q, cks_q, fe_q;
  logic       rst_seen_q;
  logic [2:0] kind_q;
  logic       ack_q;
  logic [7:0] flen_q, len_q, id_q, sum_q;
  logic       ok_q;
  logic [8:0] base_q, cnt_q;
  logic [2:0] k_q;

  logic       out_valid_q, out_last_q, out_rst_q, out_rdy_q, out_ack_q;
  logic [2:0] out_kind_q;
  logic [7:0] out_pay_q, out_ackid_q, out_flen_q;

  // packet checks
  logic [63:0] bytes_w;
  logic        all_zero, all_ones, is_sync, sum_bad, header;
  assign bytes_w  = {b_q[7], b_q[6], b_q[5], b_q[4], b_q[3], b_q[2], b_q[1], b_q[0]};
  assign all_zero = (bytes_w == '0);
  assign all_ones = (bytes_w == '1);
  assign is_sync  = (bytes_w == SyncRev);
  assign sum_bad  = ((b_q[1] ^ b_q[2] ^ b_q[3] ^ b_q[4] ^ b_q[5] ^ b_q[6]) != b_q[7]);
  assign header   = (b_q[1] == 8'hFF) && (b_q[2] == 8'hA5) && (b_q[3] == 8'h5A) &&
                    (b_q[4] == b_q[0]);

  logic [7:0] c_inv, c_cks, c_fe, c_id;
  logic       c_rdy, c_rs, c_write;
  logic [2:0] c_kind;
  logic [5:0] c_exp, c_rec;

  always_comb begin
    c_inv   = inv_q;
    c_cks   = cks_q;
    c_fe    = fe_q;
    c_rdy   = ready_q;
    c_rs    = rst_seen_q;
    c_id    = cur_id_q;
    c_exp   = exp_q;
    c_rec   = rec_q;
    c_write = 1'b0;
    c_kind  = spfr_pkg::KIND_UNDEF;
    if (all_zero) begin
      c_kind = spfr_pkg::KIND_ZERO;
      c_inv  = spfr_pkg::sat_inc(inv_q);
      if (c_inv > max_inv_q) begin
        c_inv = '0; c_cks = '0; c_fe = '0; c_rdy = 1'b0; c_rs = 1'b1;
      end
    end else if (is_sync) begin
      c_kind = spfr_pkg::KIND_SYNC;
      c_rdy  = 1'b1;
    end else if (sum_bad) begin
      if (all_ones) begin
        c_kind = spfr_pkg::KIND_ONES;
        c_inv  = spfr_pkg::sat_inc(inv_q);
        if (c_inv > max_inv_q) begin
          c_inv = '0; c_cks = '0; c_fe = '0; c_rdy = 1'b0; c_rs = 1'b1;
        end
      end else begin
        c_kind = spfr_pkg::KIND_BAD_SUM;
        c_cks  = spfr_pkg::sat_inc(cks_q);
      end
      if (c_cks > max_cks_q) begin
        c_inv = '0; c_cks = '0; c_fe = '0; c_rdy = 1'b0; c_rs = 1'b1;
      end
    end else if (ready_q) begin
      if (header) begin
        c_id = b_q[0];
        // header while the previous frame is still open
        if ((exp_q != rec_q) && (exp_q != '0)) begin
          c_fe = spfr_pkg::sat_inc(fe_q);
          if (c_fe > max_fe_q) begin
            c_inv = '0; c_cks = '0; c_fe = '0; c_rdy = 1'b0; c_rs = 1'b1;
          end
        end
        c_exp = spfr_pkg::packets_for_len(b_q[5]);
        c_rec = '0;
      end
      if (b_q[0] == c_id) begin
        c_write = 1'b1;
        c_kind  = spfr_pkg::KIND_ACCEPTED;
      end else begin
        c_fe = spfr_pkg::sat_inc(c_fe);
        if (c_fe > max_fe_q) begin
          c_inv = '0; c_cks = '0; c_fe = '0; c_rdy = 1'b0; c_rs = 1'b1;
        end
      end
    end
  end

  // store addressing
  logic [9:0]    wa_full, ea_full;
  logic          wr_in_range;
  logic [7:0]    wdata;
  logic [2:0]    wsel;
  logic [AW-1:0] raddr;
  logic          re;
  logic [7:0]    rdata;
  logic [7:0]    j_cks;
  logic          out_load;

  assign wa_full     = {1'b0, base_q} + {7'd0, k_q};
  assign wr_in_range = (wa_full < FB);
  assign wsel        = k_q + 3'd1;
  assign wdata       = b_q[wsel];
  assign ea_full     = {1'b0, cnt_q} + 10'd5;
  assign raddr       = cmd_i.emit_rd ? ea_full[AW-1:0] : cnt_q[AW-1:0];
  assign re          = cmd_i.emit_rd || cmd_i.walk_rd;
  assign j_cks       = spfr_pkg::sat_inc(cks_q);
  assign out_load    = cmd_i.put_single || cmd_i.emit_put;

  spfr_ram #(
    .WIDTH(8),
    .DEPTH(FRAME_BYTES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.write && wr_in_range),
    .waddr_i(wa_full[AW-1:0]),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    sts_o            = '0;
    sts_o.do_write   = c_write;
    sts_o.write_last = (k_q == 3'd5);
    sts_o.frame_done = (exp_q == rec_q);
    sts_o.too_long   = (({2'b0, len_q} + 10'd6) >= FB);
    sts_o.walk_last  = ({1'b0, cnt_q} == ({2'b0, len_q} + 10'd5));
    sts_o.sum_ok     = ok_q;
    sts_o.len_zero   = (len_q == '0);
    sts_o.emit_last  = (({1'b0, cnt_q} + 10'd1) == {2'b0, len_q});
    sts_o.out_free   = !out_valid_q || !out_stall_i;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_inv_q  <= spfr_pkg::LIMIT_RESET;
      max_cks_q  <= spfr_pkg::LIMIT_RESET;
      max_fe_q   <= spfr_pkg::LIMIT_RESET;
      ready_q    <= 1'b0;
      cur_id_q   <= '0;
      exp_q      <= '0;
      rec_q      <= '0;
      inv_q      <= '0;
      cks_q      <= '0;
      fe_q       <= '0;
      rst_seen_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          spfr_pkg::CFG_MAX_INVALID:  max_inv_q <= cfg_data_i;
          spfr_pkg::CFG_MAX_CHECKSUM: max_cks_q <= cfg_data_i;
          spfr_pkg::CFG_MAX_FRAME:    max_fe_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.capture) begin
        rst_seen_q <= 1'b0;
      end
      if (cmd_i.classify) begin
        inv_q      <= c_inv;
        cks_q      <= c_cks;
        fe_q       <= c_fe;
        ready_q    <= c_rdy;
        rst_seen_q <= c_rs;
        cur_id_q   <= c_id;
        exp_q      <= c_exp;
        rec_q      <= c_rec;
      end
      if (cmd_i.inc_rec && (rec_q != 6'd63)) begin
        rec_q <= rec_q + 6'd1;
      end
      if (cmd_i.fin_start && sts_o.too_long) begin
        inv_q <= '0; cks_q <= '0; fe_q <= '0; ready_q <= 1'b0; rst_seen_q <= 1'b1;
      end
      if (cmd_i.judge) begin
        if (ok_q) begin
          fe_q  <= '0;
          inv_q <= '0;
        end else if (j_cks > max_cks_q) begin
          inv_q <= '0; cks_q <= '0; fe_q <= '0; ready_q <= 1'b0; rst_seen_q <= 1'b1;
        end else begin
          cks_q <= j_cks;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      b_q[0] <= byte_0_i;
      b_q[1] <= byte_1_i;
      b_q[2] <= byte_2_i;
      b_q[3] <= byte_3_i;
      b_q[4] <= byte_4_i;
      b_q[5] <= byte_5_i;
      b_q[6] <= byte_6_i;
      b_q[7] <= byte_7_i;
    end
    if (cmd_i.classify) begin
      kind_q <= c_kind;
      ack_q  <= 1'b0;
      flen_q <= '0;
      base_q <= {3'd0, c_rec} * 9'd6;
      k_q    <= '0;
    end
    if (cmd_i.write) begin
      k_q <= k_q + 3'd1;
      if (wa_full == 10'd3) id_q  <= wdata;
      if (wa_full == 10'd4) len_q <= wdata;
    end
    if (cmd_i.inc_rec) begin
      kind_q <= spfr_pkg::KIND_ACCEPTED;
    end
    if (cmd_i.fin_start) begin
      cnt_q  <= '0;
      sum_q  <= '0;
      kind_q <= spfr_pkg::KIND_FRAME_BAD;
      flen_q <= len_q;
    end
    if (cmd_i.walk_acc) begin
      if (sts_o.walk_last) begin
        ok_q <= (sum_q == rdata);
      end else begin
        sum_q <= sum_q ^ rdata;
        cnt_q <= cnt_q + 9'd1;
      end
    end
    if (cmd_i.judge) begin
      cnt_q  <= '0;
      flen_q <= len_q;
      if (ok_q) begin
        kind_q <= spfr_pkg::KIND_FRAME_GOOD;
        ack_q  <= (id_q[7:6] == 2'b11);
      end else begin
        kind_q <= spfr_pkg::KIND_FRAME_BAD;
      end
    end
    if (cmd_i.emit_put) begin
      cnt_q <= cnt_q + 9'd1;
    end
    if (out_load) begin
      out_kind_q  <= cmd_i.emit_put ? spfr_pkg::KIND_FRAME_GOOD : kind_q;
      out_pay_q   <= cmd_i.emit_put ? rdata : 8'd0;
      out_last_q  <= cmd_i.emit_put ? sts_o.emit_last : 1'b1;
      out_rst_q   <= rst_seen_q;
      out_rdy_q   <= ready_q;
      out_ack_q   <= ack_q;
      out_ackid_q <= ack_q ? id_q : 8'd0;
      out_flen_q  <= flen_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign packet_kind_o   = out_kind_q;
  assign payload_byte_o  = out_pay_q;
  assign last_result_o   = out_last_q;
  assign reset_request_o = out_rst_q;
  assign partner_ready_o = out_rdy_q;
  assign ack_needed_o    = out_ack_q;
  assign ack_id_o        = out_ackid_q;
  assign frame_len_o     = out_flen_q;

endmodule

// File: rtl/spfr_checker.sv
// ----------------------------------------------------------------------------
// spfr_checker
// port-level checks of the receiver, bound to the top level
// ----------------------------------------------------------------------------
module spfr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [2:0] packet_kind_o,
  input logic [7:0] payload_byte_o,
  input logic       ack_needed_o,
  input logic [7:0] ack_id_o,
  input logic [7:0] frame_len_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // one packet at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after a transfer");

  a_payload_only_good: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (packet_kind_o != spfr_pkg::KIND_FRAME_GOOD) |-> payload_byte_o == 8'd0)
    else $error("payload on a non-frame result");

  a_ack_good: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ack_needed_o |->
      (packet_kind_o == spfr_pkg::KIND_FRAME_GOOD) && (ack_id_o[7:6] == 2'b11))
    else $error("ack on a result that is not a good frame");

  a_len_frames_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (packet_kind_o != spfr_pkg::KIND_FRAME_GOOD) &&
      (packet_kind_o != spfr_pkg::KIND_FRAME_BAD) |-> frame_len_o == 8'd0)
    else $error("frame length on a packet result");

endmodule

bind spi_packet_frame_receiver_core spfr_checker u_spfr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .packet_kind_o (packet_kind_o),
  .payload_byte_o(payload_byte_o),
  .ack_needed_o  (ack_needed_o),
  .ack_id_o      (ack_id_o),
  .frame_len_o   (frame_len_o)
);
